// ===== src/pcm_pkg.sv =====
// pcm_pkg: shared types, constants and helpers for the paged character machine step core
// used by pcm_xlate and paged_char_machine_step_core; no dependencies
`default_nettype none

package pcm_pkg;

    localparam int FRAMES          = 30;
    localparam int WORDS_PER_FRAME = 10;
    localparam int MEM_WORDS       = FRAMES * WORDS_PER_FRAME;
    localparam int MEM_AW          = $clog2(MEM_WORDS);

    localparam int PTB_W  = 9;
    localparam int TLIM_W = 14;
    localparam int CFG_W  = 14;

    localparam logic [31:0]       SPACES   = 32'h2020_2020;
    localparam logic [TLIM_W-1:0] TIME_SAT = 14'd10000;

    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] OP_LR = 16'h4C52;
    localparam logic [15:0] OP_SR = 16'h5352;
    localparam logic [15:0] OP_CR = 16'h4352;
    localparam logic [15:0] OP_BT = 16'h4254;
    localparam logic [15:0] OP_GD = 16'h4744;
    localparam logic [15:0] OP_PD = 16'h5044;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_EXEC  = 2'd2,
        FN_START = 2'd3
    } t_func;

    typedef enum logic [0:0] {
        CFG_PT_BASE    = 1'b0,
        CFG_TIME_LIMIT = 1'b1
    } t_cfg;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_HALT        = 4'd1,
        ST_READ_REQ    = 4'd2,
        ST_WRITE_REQ   = 4'd3,
        ST_OPCODE_ERR  = 4'd4,
        ST_OPERAND_ERR = 4'd5,
        ST_VALID_FAULT = 4'd6,
        ST_INVAL_FAULT = 4'd7,
        ST_BAD_ENTRY   = 4'd8
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_IENT,
        S_IR,
        S_OENT,
        S_OPR,
        S_RD,
        S_DONE
    } t_state;

    // result of the shared translation unit
    typedef struct packed {
        logic [MEM_AW-1:0] pte_addr;
        logic              pte_ok;
        logic              fault;
        logic              bad;
        logic [MEM_AW-1:0] ra;
    } t_xlate;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // low nibble of an ascii digit is its value
    function automatic logic [3:0] digit_val(input logic [7:0] c);
        return c[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/pcm_xlate.sv =====
// pcm_xlate: page table lookup unit, shared by instruction fetch and operand mapping
// depends on pcm_pkg
`default_nettype none

module pcm_xlate (
    input  wire logic [pcm_pkg::PTB_W-1:0] i_base,
    input  wire logic [3:0]                i_tens,
    input  wire logic [3:0]                i_ones,
    input  wire logic [31:0]               i_entry,
    output pcm_pkg::t_xlate                o_xl
);

    logic [9:0] pte_sum;
    logic       pte_ok;
    logic [3:0] d0, d1, d2, d3;
    logic       all_digit;
    logic [6:0] frame;
    logic [9:0] ra_full;
    logic       fault;
    logic       bad;

    always_comb begin
        pte_sum = {1'b0, i_base} + {6'b0, i_tens};
        pte_ok  = pte_sum < 10'(pcm_pkg::MEM_WORDS);

        d0 = pcm_pkg::digit_val(i_entry[31:24]);
        d1 = pcm_pkg::digit_val(i_entry[23:16]);
        d2 = pcm_pkg::digit_val(i_entry[15:8]);
        d3 = pcm_pkg::digit_val(i_entry[7:0]);
        all_digit = pcm_pkg::is_digit(i_entry[31:24]) && pcm_pkg::is_digit(i_entry[23:16])
                 && pcm_pkg::is_digit(i_entry[15:8])  && pcm_pkg::is_digit(i_entry[7:0]);

        // upper two digits must be zero for any frame below the frame count
        frame   = ({3'b0, d2} << 3) + ({3'b0, d2} << 1) + {3'b0, d3};
        ra_full = ({3'b0, frame} << 3) + ({3'b0, frame} << 1) + {6'b0, i_ones};

        fault = i_entry == pcm_pkg::SPACES;
        bad   = !fault && (!all_digit || (d0 != 4'd0) || (d1 != 4'd0)
                           || (frame >= 7'(pcm_pkg::FRAMES)));

        o_xl.pte_addr = pte_ok ? pcm_pkg::MEM_AW'(pte_sum) : '0;
        o_xl.pte_ok   = pte_ok;
        o_xl.fault    = fault;
        o_xl.bad      = bad;
        o_xl.ra       = (!fault && !bad) ? pcm_pkg::MEM_AW'(ra_full) : '0;
    end

endmodule

`default_nettype wire

// ===== src/paged_char_machine_step_core.sv =====
// paged_char_machine_step_core: top level, sequencer, word memory and machine registers
// depends on pcm_pkg and pcm_xlate
`default_nettype none

// User-mode step core of a paged four-character machine. After reset the block runs a
// clearing pass that fills the 300-word memory with ascii spaces; it takes
// no item meanwhile (configuration writes are taken). One item is in work at a time, all
// through a single-port memory with registered read data and one shared page-table
// translation unit. A memory write or start-job item goes straight to the done state, a
// memory read through one read state; an execute item makes up to four dependent memory
// reads (page entry, instruction, page entry, operand), then uses the operand and hands
// over the result; a page table address past the end of memory ends an execute at once.
// The result sits in an output register, so a new item is taken while it waits; the next
// result then holds in its done state until that register is free.
module paged_char_machine_step_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [13:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [8:0]  i_mem_address,
    input  wire logic [31:0] i_write_word,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_status,
    output logic             o_time_exceeded,
    output logic [8:0]       o_real_address,
    output logic [6:0]       o_instr_counter,
    output logic [31:0]      o_read_word,
    output logic             o_compare_flag
);

    localparam int AW = pcm_pkg::MEM_AW;

    pcm_pkg::t_state r_state, n_state;

    logic [31:0] r_mem [pcm_pkg::MEM_WORDS];
    logic [31:0] r_rdata;
    logic          m_we;
    logic [AW-1:0] m_addr;
    logic [31:0]   m_wdata;

    logic [AW-1:0] r_clr_cnt;
    logic [pcm_pkg::PTB_W-1:0]  r_pt_base;
    logic [pcm_pkg::TLIM_W-1:0] r_time_limit;

    logic [31:0] r_gr;
    logic [3:0]  r_ic_tens, r_ic_ones;
    logic [3:0]  r_prev_tens, r_prev_ones;
    logic [3:0]  r_op_tens, r_op_ones;
    logic [pcm_pkg::TLIM_W-1:0] r_exec;
    logic        r_toggle;
    logic [15:0] r_code;

    pcm_pkg::t_status r_status;
    logic [8:0]  r_ra;
    logic [31:0] r_rword;
    logic        r_rd_ok;

    pcm_pkg::t_status r_out_status;
    logic        r_out_valid;
    logic        r_out_tex;
    logic [8:0]  r_out_ra;
    logic [6:0]  r_out_ic;
    logic [31:0] r_out_rword;
    logic        r_out_cf;

    pcm_pkg::t_func   in_func;
    pcm_pkg::t_xlate  xl;
    logic [3:0]  xl_tens, xl_ones;
    logic        in_fire;
    logic        out_free;
    logic        addr_ok;
    logic        halt;
    logic        op_ok;
    logic [3:0]  op_tens, op_ones;
    logic        mapped;
    logic [3:0]  inc_tens, inc_ones;
    logic [6:0]  ic_bin;

    assign in_func  = pcm_pkg::t_func'(i_func);
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign addr_ok  = {1'b0, i_mem_address} < 10'(pcm_pkg::MEM_WORDS);
    assign mapped   = !xl.fault && !xl.bad;
    assign ic_bin   = ({3'b0, r_ic_tens} << 3) + ({3'b0, r_ic_tens} << 1) + {3'b0, r_ic_ones};

    // instruction word checks, valid while r_rdata holds the fetched word
    always_comb begin
        halt    = (r_rdata[31:24] == pcm_pkg::CH_H) && (r_rdata[23:16] == pcm_pkg::CH_SPACE);
        op_ok   = 1'b1;
        op_tens = 4'd0;
        op_ones = 4'd0;
        priority if (pcm_pkg::is_digit(r_rdata[15:8]) && pcm_pkg::is_digit(r_rdata[7:0])) begin
            op_tens = pcm_pkg::digit_val(r_rdata[15:8]);
            op_ones = pcm_pkg::digit_val(r_rdata[7:0]);
        end else if (r_rdata[15:8] == pcm_pkg::CH_SPACE && pcm_pkg::is_digit(r_rdata[7:0])) begin
            op_ones = pcm_pkg::digit_val(r_rdata[7:0]);
        end else if (pcm_pkg::is_digit(r_rdata[15:8]) && r_rdata[7:0] == pcm_pkg::CH_SPACE) begin
            op_ones = pcm_pkg::digit_val(r_rdata[15:8]);
        end else begin
            op_ok = 1'b0;
        end
    end

    // decimal counter advance, wraps at 100
    always_comb begin
        if (r_ic_ones == 4'd9) begin
            inc_ones = 4'd0;
            inc_tens = (r_ic_tens == 4'd9) ? 4'd0 : r_ic_tens + 4'd1;
        end else begin
            inc_ones = r_ic_ones + 4'd1;
            inc_tens = r_ic_tens;
        end
    end

    pcm_xlate u_xlate (
        .i_base  (r_pt_base),
        .i_tens  (xl_tens),
        .i_ones  (xl_ones),
        .i_entry (r_rdata),
        .o_xl    (xl)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcm_pkg::S_CLEAR: begin
                if (r_clr_cnt == AW'(pcm_pkg::MEM_WORDS - 1)) n_state = pcm_pkg::S_IDLE;
            end
            pcm_pkg::S_IDLE: begin
                if (in_fire) begin
                    unique case (in_func)
                        pcm_pkg::FN_EXEC:  n_state = xl.pte_ok ? pcm_pkg::S_IENT : pcm_pkg::S_DONE;
                        pcm_pkg::FN_READ:  n_state = pcm_pkg::S_RD;
                        pcm_pkg::FN_WRITE,
                        pcm_pkg::FN_START: n_state = pcm_pkg::S_DONE;
                    endcase
                end
            end
            pcm_pkg::S_IENT: n_state = mapped ? pcm_pkg::S_IR : pcm_pkg::S_DONE;
            pcm_pkg::S_IR: begin
                n_state = (halt || !op_ok || !xl.pte_ok) ? pcm_pkg::S_DONE : pcm_pkg::S_OENT;
            end
            pcm_pkg::S_OENT: begin
                n_state = (mapped && (r_code == pcm_pkg::OP_LR || r_code == pcm_pkg::OP_CR))
                          ? pcm_pkg::S_OPR : pcm_pkg::S_DONE;
            end
            pcm_pkg::S_OPR,
            pcm_pkg::S_RD:   n_state = pcm_pkg::S_DONE;
            pcm_pkg::S_DONE: if (out_free) n_state = pcm_pkg::S_IDLE;
        endcase
    end

    // memory port, translation unit inputs and handshake
    always_comb begin
        o_in_ready = r_state == pcm_pkg::S_IDLE;
        m_we       = 1'b0;
        m_addr     = '0;
        m_wdata    = i_write_word;
        xl_tens    = r_ic_tens;
        xl_ones    = r_ic_ones;
        unique case (r_state)
            pcm_pkg::S_CLEAR: begin
                m_we    = 1'b1;
                m_addr  = r_clr_cnt;
                m_wdata = pcm_pkg::SPACES;
            end
            pcm_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (in_func == pcm_pkg::FN_EXEC) begin
                        m_addr = xl.pte_addr;
                    end else if (addr_ok) begin
                        m_addr = AW'(i_mem_address);
                        m_we   = in_func == pcm_pkg::FN_WRITE;
                    end
                end
            end
            pcm_pkg::S_IENT: m_addr = xl.ra;
            pcm_pkg::S_IR: begin
                xl_tens = op_tens;
                m_addr  = xl.pte_addr;
            end
            pcm_pkg::S_OENT: begin
                xl_ones = r_op_ones;
                m_addr  = xl.ra;
                m_wdata = r_gr;
                m_we    = mapped && (r_code == pcm_pkg::OP_SR);
            end
            pcm_pkg::S_OPR,
            pcm_pkg::S_RD,
            pcm_pkg::S_DONE: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we) r_mem[m_addr] <= m_wdata;
        r_rdata <= r_mem[m_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcm_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt_base    <= '0;
            r_time_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (pcm_pkg::t_cfg'(i_cfg_index))
                pcm_pkg::CFG_PT_BASE:    r_pt_base    <= i_cfg_data[pcm_pkg::PTB_W-1:0];
                pcm_pkg::CFG_TIME_LIMIT: r_time_limit <= i_cfg_data[pcm_pkg::TLIM_W-1:0];
            endcase
        end
    end

    // payload registers of the output stage
    always_ff @(posedge i_clk) begin
        if (r_state == pcm_pkg::S_DONE && out_free) begin
            r_out_status <= r_status;
            r_out_tex    <= r_exec > r_time_limit;
            r_out_ra     <= r_ra;
            r_out_ic     <= ic_bin;
            r_out_rword  <= r_rword;
            r_out_cf     <= r_toggle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_gr        <= pcm_pkg::SPACES;
            r_ic_tens   <= '0;
            r_ic_ones   <= '0;
            r_exec      <= '0;
            r_toggle    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == pcm_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                pcm_pkg::S_CLEAR: r_clr_cnt <= r_clr_cnt + AW'(1);
                pcm_pkg::S_IDLE: begin
                    if (in_fire) begin
                        r_status <= (in_func == pcm_pkg::FN_EXEC && !xl.pte_ok)
                                    ? pcm_pkg::ST_BAD_ENTRY : pcm_pkg::ST_OK;
                        r_ra     <= '0;
                        r_rword  <= '0;
                        r_rd_ok  <= addr_ok;
                        if (in_func == pcm_pkg::FN_START) begin
                            r_ic_tens <= '0;
                            r_ic_ones <= '0;
                            r_exec    <= '0;
                        end
                    end
                end
                pcm_pkg::S_IENT: begin
                    if (xl.fault)    r_status <= pcm_pkg::ST_INVAL_FAULT;
                    else if (xl.bad) r_status <= pcm_pkg::ST_BAD_ENTRY;
                end
                pcm_pkg::S_IR: begin
                    r_code <= r_rdata[31:16];
                    if (halt) begin
                        r_status <= pcm_pkg::ST_HALT;
                    end else begin
                        r_prev_tens <= r_ic_tens;
                        r_prev_ones <= r_ic_ones;
                        r_ic_tens   <= inc_tens;
                        r_ic_ones   <= inc_ones;
                        r_op_tens   <= op_tens;
                        r_op_ones   <= op_ones;
                        if (!op_ok)           r_status <= pcm_pkg::ST_OPERAND_ERR;
                        else if (!xl.pte_ok)  r_status <= pcm_pkg::ST_BAD_ENTRY;
                    end
                end
                pcm_pkg::S_OENT: begin
                    if (xl.fault) begin
                        // read and store requests are retried once the page is there
                        if (r_code == pcm_pkg::OP_GD || r_code == pcm_pkg::OP_SR) begin
                            r_ic_tens <= r_prev_tens;
                            r_ic_ones <= r_prev_ones;
                            r_status  <= pcm_pkg::ST_VALID_FAULT;
                        end else begin
                            r_status  <= pcm_pkg::ST_INVAL_FAULT;
                        end
                    end else if (xl.bad) begin
                        r_status <= pcm_pkg::ST_BAD_ENTRY;
                    end else begin
                        r_ra <= 9'(xl.ra);
                        if (r_exec < pcm_pkg::TIME_SAT) r_exec <= r_exec + 14'd1;
                        unique case (r_code)
                            pcm_pkg::OP_LR,
                            pcm_pkg::OP_SR,
                            pcm_pkg::OP_CR: r_status <= pcm_pkg::ST_OK;
                            pcm_pkg::OP_BT: begin
                                if (r_toggle) begin
                                    r_ic_tens <= r_op_tens;
                                    r_ic_ones <= r_op_ones;
                                end
                            end
                            pcm_pkg::OP_GD: r_status <= pcm_pkg::ST_READ_REQ;
                            pcm_pkg::OP_PD: r_status <= pcm_pkg::ST_WRITE_REQ;
                            default:        r_status <= pcm_pkg::ST_OPCODE_ERR;
                        endcase
                    end
                end
                pcm_pkg::S_OPR: begin
                    if (r_code == pcm_pkg::OP_LR) r_gr <= r_rdata;
                    else                          r_toggle <= r_rdata == r_gr;
                end
                pcm_pkg::S_RD: r_rword <= r_rd_ok ? r_rdata : '0;
                pcm_pkg::S_DONE: ;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_time_exceeded = r_out_tex;
    assign o_real_address  = r_out_ra;
    assign o_instr_counter = r_out_ic;
    assign o_read_word     = r_out_rword;
    assign o_compare_flag  = r_out_cf;

    a_ic_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ic_tens <= 4'd9) && (r_ic_ones <= 4'd9))
        else $error("instruction counter digit out of decimal range");

    a_exec_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exec <= pcm_pkg::TIME_SAT)
        else $error("executed count passed its saturation value");

    a_mem_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_we |-> ({1'b0, m_addr} < (AW + 1)'(pcm_pkg::MEM_WORDS)))
        else $error("memory write beyond the last word");

    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcm_pkg::S_CLEAR) |-> !o_in_ready)
        else $error("transfer taken during the clearing pass");

endmodule

`default_nettype wire

// ===== tb/tb_paged_char_machine_step_core.sv =====
// tb_paged_char_machine_step_core: self-checking testbench for the paged character machine
// step core; a scoreboard class predicts every result, plain tasks drive both channels
// depends on pcm_pkg and paged_char_machine_step_core
`timescale 1ns / 1ps

module tb_paged_char_machine_step_core;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam int         MAP_OK      = 0;
    localparam int         MAP_FAULT   = 1;
    localparam int         MAP_BAD     = 2;
    localparam int         IC_MOD      = 100;
    localparam int         MIX_ITEMS   = 65;
    localparam int         RUN_LIMIT_NS = 3_600_000;

    typedef struct {
        pcm_pkg::t_status status;
        logic        time_over;
        logic [8:0]  real_addr;
        logic [6:0]  counter;
        logic [31:0] word;
        logic        cmp;
    } t_step_result;

    class machine_step_checker;
        logic [31:0]  mem [pcm_pkg::MEM_WORDS];
        logic [31:0]  gen_reg;
        int           ic;
        int           executed;
        logic         toggle;
        int           pt_base;
        int           limit;
        t_step_result pending_steps[$];
        int           errors;
        int           checked;
        int           status_seen[16];

        function new();
            foreach (mem[i]) mem[i] = pcm_pkg::SPACES;
            foreach (status_seen[i]) status_seen[i] = 0;
            gen_reg  = pcm_pkg::SPACES;
            ic       = 0;
            executed = 0;
            toggle   = 1'b0;
            pt_base  = 0;
            limit    = 0;
            errors   = 0;
            checked  = 0;
        endfunction

        function void set_register(pcm_pkg::t_cfg idx, logic [pcm_pkg::CFG_W-1:0] value);
            if (idx == pcm_pkg::CFG_PT_BASE) pt_base = int'(value[pcm_pkg::PTB_W-1:0]);
            else limit = int'(value[pcm_pkg::TLIM_W-1:0]);
        endfunction

        function bit is_num(logic [7:0] c);
            return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        endfunction

        function int num_val(logic [7:0] c);
            return int'(c) - int'(CHAR_ZERO);
        endfunction

        // page table walk: an entry is a frame number in four ascii decimal digits
        function int map_page(int va, output int ra);
            int          at;
            int          frame;
            int          i;
            logic [31:0] entry;
            logic [7:0]  c;
            ra    = 0;
            frame = 0;
            at    = pt_base + va / pcm_pkg::WORDS_PER_FRAME;
            if (at >= pcm_pkg::MEM_WORDS) return MAP_BAD;
            entry = mem[at];
            if (entry == pcm_pkg::SPACES) return MAP_FAULT;
            for (i = 0; i < 4; i++) begin
                c = entry[31-8*i -: 8];
                if (!is_num(c)) return MAP_BAD;
                frame = frame * 10 + num_val(c);
            end
            if (frame >= pcm_pkg::FRAMES) return MAP_BAD;
            ra = frame * pcm_pkg::WORDS_PER_FRAME + va % pcm_pkg::WORDS_PER_FRAME;
            return MAP_OK;
        endfunction

        function pcm_pkg::t_status run_instr(output int ra_out);
            int          ra;
            int          op;
            int          prev;
            int          r;
            logic [31:0] iw;
            logic [7:0]  hi;
            logic [7:0]  lo;
            ra_out = 0;
            op     = 0;
            r = map_page(ic, ra);
            if (r == MAP_FAULT) return pcm_pkg::ST_INVAL_FAULT;
            if (r == MAP_BAD) return pcm_pkg::ST_BAD_ENTRY;
            iw = mem[ra];
            if (iw[31:24] == pcm_pkg::CH_H && iw[23:16] == pcm_pkg::CH_SPACE)
                return pcm_pkg::ST_HALT;
            prev = ic;
            ic   = (ic + 1) % IC_MOD;
            hi   = iw[15:8];
            lo   = iw[7:0];
            if (is_num(hi) && is_num(lo)) op = num_val(hi) * 10 + num_val(lo);
            else if (hi == pcm_pkg::CH_SPACE && is_num(lo)) op = num_val(lo);
            else if (is_num(hi) && lo == pcm_pkg::CH_SPACE) op = num_val(hi);
            else return pcm_pkg::ST_OPERAND_ERR;
            r = map_page(op, ra);
            if (r == MAP_FAULT) begin
                // load and store faults are retried, so the counter goes back
                if (iw[31:16] == pcm_pkg::OP_GD || iw[31:16] == pcm_pkg::OP_SR) begin
                    ic = prev;
                    return pcm_pkg::ST_VALID_FAULT;
                end
                return pcm_pkg::ST_INVAL_FAULT;
            end
            if (r == MAP_BAD) return pcm_pkg::ST_BAD_ENTRY;
            ra_out = ra;
            if (executed < pcm_pkg::TIME_SAT) executed++;
            case (iw[31:16])
                pcm_pkg::OP_LR: begin
                    gen_reg = mem[ra];
                    return pcm_pkg::ST_OK;
                end
                pcm_pkg::OP_SR: begin
                    mem[ra] = gen_reg;
                    return pcm_pkg::ST_OK;
                end
                pcm_pkg::OP_CR: begin
                    toggle = (mem[ra] == gen_reg);
                    return pcm_pkg::ST_OK;
                end
                pcm_pkg::OP_BT: begin
                    if (toggle) ic = op;
                    return pcm_pkg::ST_OK;
                end
                pcm_pkg::OP_GD: return pcm_pkg::ST_READ_REQ;
                pcm_pkg::OP_PD: return pcm_pkg::ST_WRITE_REQ;
                default: return pcm_pkg::ST_OPCODE_ERR;
            endcase
        endfunction

        function void note_item(pcm_pkg::t_func fn, logic [8:0] addr, logic [31:0] w);
            t_step_result s;
            int           ra;
            ra       = 0;
            s.status = pcm_pkg::ST_OK;
            s.word   = '0;
            case (fn)
                pcm_pkg::FN_WRITE: if (addr < pcm_pkg::MEM_WORDS) mem[addr] = w;
                pcm_pkg::FN_READ:  if (addr < pcm_pkg::MEM_WORDS) s.word = mem[addr];
                pcm_pkg::FN_EXEC:  s.status = run_instr(ra);
                default: begin
                    ic       = 0;
                    executed = 0;
                end
            endcase
            s.time_over = (executed > limit);
            s.real_addr = 9'(ra);
            s.counter   = 7'(ic);
            s.cmp       = toggle;
            pending_steps.push_back(s);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_step(logic [3:0] st, logic tov, logic [8:0] ra, logic [6:0] cnt,
                                 logic [31:0] rw, logic cmp);
            t_step_result s;
            if (pending_steps.size() == 0) begin
                $display("%0t: result transfer with nothing outstanding, status %0d",
                         $time, st);
                errors++;
                return;
            end
            s = pending_steps.pop_front();
            checked++;
            status_seen[s.status]++;
            compare_field("status", s.status, st);
            compare_field("time_exceeded", s.time_over, tov);
            compare_field("real_address", s.real_addr, ra);
            compare_field("instr_counter", s.counter, cnt);
            compare_field("read_word", s.word, rw);
            compare_field("compare_flag", s.cmp, cmp);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [13:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_func;
    logic [8:0]  i_mem_address;
    logic [31:0] i_write_word;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [3:0]  o_status;
    logic        o_time_exceeded;
    logic [8:0]  o_real_address;
    logic [6:0]  o_instr_counter;
    logic [31:0] o_read_word;
    logic        o_compare_flag;

    machine_step_checker chk;
    logic                gaps_on;
    int                  frame_of_page[10];
    int                  n_items;
    int                  n_exec;
    int                  n_settings;

    paged_char_machine_step_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_mem_address   (i_mem_address),
        .i_write_word    (i_write_word),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_time_exceeded (o_time_exceeded),
        .o_real_address  (o_real_address),
        .o_instr_counter (o_instr_counter),
        .o_read_word     (o_read_word),
        .o_compare_flag  (o_compare_flag)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= !gaps_on || ($urandom_range(0, 99) >= 12);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            chk.check_step(o_status, o_time_exceeded, o_real_address, o_instr_counter,
                           o_read_word, o_compare_flag);
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout at %0t with %0d results outstanding", $time,
                 chk.pending_steps.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [31:0] ascii4(int n);
        logic [31:0] w;
        int          v;
        int          i;
        v = n;
        w = '0;
        for (i = 0; i < 4; i++) begin
            w[8*i +: 8] = CHAR_ZERO + 8'(v % 10);
            v = v / 10;
        end
        return w;
    endfunction

    function automatic logic [31:0] make_instr();
        logic [15:0] code;
        logic [15:0] opnd;
        int          k;
        int          n;
        k = $urandom_range(0, 99);
        n = $urandom_range(0, 99);
        if (k < 18) code = pcm_pkg::OP_LR;
        else if (k < 33) code = pcm_pkg::OP_SR;
        else if (k < 48) code = pcm_pkg::OP_CR;
        else if (k < 62) code = pcm_pkg::OP_BT;
        else if (k < 74) code = pcm_pkg::OP_GD;
        else if (k < 86) code = pcm_pkg::OP_PD;
        else if (k < 90) code = {pcm_pkg::CH_H, pcm_pkg::CH_SPACE};
        else code = 16'($urandom);
        k = $urandom_range(0, 99);
        if (k < 80) opnd = {CHAR_ZERO + 8'(n / 10), CHAR_ZERO + 8'(n % 10)};
        else if (k < 88) opnd = {pcm_pkg::CH_SPACE, CHAR_ZERO + 8'(n % 10)};
        else if (k < 94) opnd = {CHAR_ZERO + 8'(n % 10), pcm_pkg::CH_SPACE};
        else opnd = 16'($urandom);
        return {code, opnd};
    endfunction

    // a small pool of data words so that compares hit equality now and then
    function automatic logic [31:0] data_word();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4) return pcm_pkg::SPACES;
        if (k < 7) return "ABCD";
        return $urandom;
    endfunction

    task automatic send(pcm_pkg::t_func fn, logic [8:0] addr, logic [31:0] w);
        while (gaps_on && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= fn;
        i_mem_address <= addr;
        i_write_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        chk.note_item(fn, addr, w);
        n_items++;
        if (fn == pcm_pkg::FN_EXEC) n_exec++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (chk.pending_steps.size() != 0) @(negedge i_clk);
    endtask

    task automatic program_registers(int ptb, int tlim);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= pcm_pkg::CFG_PT_BASE;
        i_cfg_data  <= ptb[13:0];
        @(negedge i_clk);
        i_cfg_index <= pcm_pkg::CFG_TIME_LIMIT;
        i_cfg_data  <= tlim[13:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        chk.set_register(pcm_pkg::CFG_PT_BASE, ptb[13:0]);
        chk.set_register(pcm_pkg::CFG_TIME_LIMIT, tlim[13:0]);
        n_settings++;
    endtask

    // page 0 always gets a usable frame so that a fresh job can start fetching
    task automatic write_entry(int ptb, int page);
        logic [31:0] w;
        int          k;
        int          f;
        k = $urandom_range(0, 99);
        f = -1;
        if (page == 0 || k < 80) begin
            do f = $urandom_range(0, pcm_pkg::FRAMES - 1);
            while (f == ptb / 10 || f == (ptb + 9) / 10);
            w = ascii4(f);
        end else if (k < 88) begin
            w = pcm_pkg::SPACES;
        end else if (k < 94) begin
            w = ascii4($urandom_range(0, 9999));
            w[8*$urandom_range(0, 3) +: 8] = 8'($urandom_range(0, 255));
        end else begin
            w = ascii4($urandom_range(pcm_pkg::FRAMES, 9999));
        end
        frame_of_page[page] = f;
        send(pcm_pkg::FN_WRITE, 9'(ptb + page), w);
    endtask

    task automatic write_program_word(int va);
        int f;
        f = frame_of_page[va / 10];
        if (f >= 0) begin
            send(pcm_pkg::FN_WRITE,
                 9'(f * pcm_pkg::WORDS_PER_FRAME + va % pcm_pkg::WORDS_PER_FRAME),
                 ($urandom_range(0, 3) == 0) ? data_word() : make_instr());
        end
    endtask

    task automatic run_directed();
        program_registers(290, 0);
        send(pcm_pkg::FN_WRITE, 290, "0001");
        send(pcm_pkg::FN_WRITE, 299, "0002");
        send(pcm_pkg::FN_WRITE, 291, "0A01");
        send(pcm_pkg::FN_WRITE, 10, {pcm_pkg::OP_LR, "90"});
        send(pcm_pkg::FN_WRITE, 11, {pcm_pkg::OP_CR, "91"});
        send(pcm_pkg::FN_WRITE, 12, {pcm_pkg::OP_BT, "99"});
        send(pcm_pkg::FN_WRITE, 29, {pcm_pkg::OP_SR, "9 "});
        send(pcm_pkg::FN_START, 0, 0);
        // load, equal compare, taken branch to 99, store that wraps the counter
        repeat (4) send(pcm_pkg::FN_EXEC, 0, 0);
        send(pcm_pkg::FN_WRITE, 10, {pcm_pkg::OP_GD, "30"});
        send(pcm_pkg::FN_EXEC, 0, 0);
        send(pcm_pkg::FN_WRITE, 10, {pcm_pkg::OP_PD, "15"});
        send(pcm_pkg::FN_EXEC, 0, 0);
        send(pcm_pkg::FN_WRITE, 11, "XY  ");
        send(pcm_pkg::FN_EXEC, 0, 0);
        send(pcm_pkg::FN_WRITE, 12, "ZZ05");
        send(pcm_pkg::FN_EXEC, 0, 0);
        send(pcm_pkg::FN_WRITE, 13, "H   ");
        send(pcm_pkg::FN_EXEC, 0, 0);
        send(pcm_pkg::FN_WRITE, 13, {pcm_pkg::OP_PD, " 7"});
        send(pcm_pkg::FN_EXEC, 0, 0);
        send(pcm_pkg::FN_WRITE, 14, {pcm_pkg::OP_GD, "95"});
        send(pcm_pkg::FN_EXEC, 0, 0);
        send(pcm_pkg::FN_WRITE, 15, {pcm_pkg::OP_LR, "39"});
        send(pcm_pkg::FN_EXEC, 0, 0);
        send(pcm_pkg::FN_WRITE, 511, 32'hFFFF_FFFF);
        send(pcm_pkg::FN_READ, 511, 32'hFFFF_FFFF);
        send(pcm_pkg::FN_READ, 300, 0);
        send(pcm_pkg::FN_READ, 19, 0);
    endtask

    task automatic run_phase(int ptb, int tlim);
        int n;
        int k;
        drain();
        program_registers(ptb, tlim);
        for (n = 0; n < 10; n++) write_entry(ptb, n);
        for (n = 0; n < 16; n++) write_program_word(n);
        repeat (10) write_program_word($urandom_range(16, 99));
        send(pcm_pkg::FN_START, 9'($urandom_range(0, 511)), $urandom);
        for (n = 0; n < MIX_ITEMS; n++) begin
            k = $urandom_range(0, 99);
            if (k < 70) send(pcm_pkg::FN_EXEC, 9'($urandom_range(0, 511)), $urandom);
            else if (k < 74) write_entry(ptb, $urandom_range(0, 9));
            else if (k < 78) write_program_word($urandom_range(0, 99));
            else if (k < 81) send(pcm_pkg::FN_WRITE, 9'($urandom_range(0, 511)), $urandom);
            else if (k < 93) begin
                send(pcm_pkg::FN_READ,
                     9'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 299)
                                                     : $urandom_range(0, 511)),
                     $urandom);
            end else send(pcm_pkg::FN_START, 9'($urandom_range(0, 511)), $urandom);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = pcm_pkg::CFG_PT_BASE;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_func        = pcm_pkg::FN_WRITE;
        i_mem_address = '0;
        i_write_word  = '0;
        gaps_on       = 1'b1;
        n_items       = 0;
        n_exec        = 0;
        n_settings    = 0;
        chk           = new();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_phase(0, 9999);
        // one whole phase with both sides streaming
        gaps_on = 1'b0;
        run_phase($urandom_range(0, 290), 12);
        gaps_on = 1'b1;
        // table near the top of memory, upper pages point past the end
        run_phase(295, 3);
        run_phase(290, $urandom_range(0, 60));
        run_phase($urandom_range(0, 290), $urandom_range(0, 9999));
        run_phase($urandom_range(0, 290), 0);

        drain();
        repeat (10) @(posedge i_clk);
        $display("%0d items (%0d executes) under %0d register settings, %0d results checked",
                 n_items, n_exec, n_settings, chk.checked);
        $display("status mix: ok %0d halt %0d rd %0d wr %0d opc %0d opr %0d vf %0d if %0d bad %0d",
                 chk.status_seen[pcm_pkg::ST_OK], chk.status_seen[pcm_pkg::ST_HALT],
                 chk.status_seen[pcm_pkg::ST_READ_REQ], chk.status_seen[pcm_pkg::ST_WRITE_REQ],
                 chk.status_seen[pcm_pkg::ST_OPCODE_ERR],
                 chk.status_seen[pcm_pkg::ST_OPERAND_ERR],
                 chk.status_seen[pcm_pkg::ST_VALID_FAULT],
                 chk.status_seen[pcm_pkg::ST_INVAL_FAULT],
                 chk.status_seen[pcm_pkg::ST_BAD_ENTRY]);
        if (chk.errors == 0 && chk.pending_steps.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
